>>> hw/rtl/rsa_lp_pkg.sv
package rsa_lp_pkg;

   // modulus datapath width
   localparam int MOD_W = 32;
   localparam int PRIME_W = 16;
   localparam int EXP_W = 32;
   localparam int CHAR_W = 8;
   localparam int LETTER_W = 5;

   // letter pair packing
   localparam int PAIR_BASE = 100;
   localparam int BLOCK_W = $clog2(25 * PAIR_BASE + 26);
   localparam logic [CHAR_W-1:0] LETTER_FIRST = 8'h41;
   localparam logic [CHAR_W-1:0] LETTER_LAST = 8'h5A;

   // configuration register indexes
   localparam logic [1:0] CSR_PRIME_P = 2'd0;
   localparam logic [1:0] CSR_PRIME_Q = 2'd1;
   localparam logic [1:0] CSR_EXPONENT = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_KEY_REJECT = 2'd2;

   // modular multiplier request and response
   typedef struct packed {
      logic             start;
      logic [MOD_W-1:0] a;
      logic [MOD_W-1:0] b;
      logic [MOD_W-1:0] n;
   } mm_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [MOD_W-1:0] value;
   } mm_rsp_type;

   // gcd unit request and response
   typedef struct packed {
      logic             start;
      logic [EXP_W-1:0] a;
      logic [MOD_W-1:0] b;
   } gcd_req_type;

   typedef struct packed {
      logic done;
      logic coprime;
   } gcd_rsp_type;

endpackage

>>> hw/rtl/rsa_lp_mulmod.sv
module rsa_lp_mulmod
   import rsa_lp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type mm_req,
   output mm_rsp_type mm_rsp
);

   localparam int CNT_W = $clog2(MOD_W);

   logic [MOD_W-1:0] r_ff, r_in;
   logic [MOD_W-1:0] a_ff, a_in;
   logic [MOD_W-1:0] b_ff, b_in;
   logic [MOD_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             phase_ff, phase_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // x + y mod n, with x, y < n
   function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] x,
                                                input logic [MOD_W-1:0] y,
                                                input logic [MOD_W-1:0] n);
      logic [MOD_W:0] s;
      logic [MOD_W:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, n};
      if (s >= {1'b0, n}) begin
         add_mod = d[MOD_W-1:0];
      end else begin
         add_mod = s[MOD_W-1:0];
      end
   endfunction

   // each multiplier bit, most significant first: double, then conditional add
   always_comb begin
      r_in = r_ff;
      a_in = a_ff;
      b_in = b_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mm_req.start) begin
         r_in = '0;
         a_in = mm_req.a;
         b_in = mm_req.b;
         n_in = mm_req.n;
         cnt_in = CNT_W'(MOD_W - 1);
         phase_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            r_in = add_mod(r_ff, r_ff, n_ff);
            phase_in = 1'b1;
         end else begin
            if (b_ff[MOD_W-1]) begin
               r_in = add_mod(r_ff, a_ff, n_ff);
            end
            b_in = {b_ff[MOD_W-2:0], 1'b0};
            phase_in = 1'b0;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
      end
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
      n_ff <= n_in;
      cnt_ff <= cnt_in;
   end

   assign mm_rsp.busy = busy_ff;
   assign mm_rsp.done = done_ff;
   assign mm_rsp.value = r_ff;

endmodule

>>> hw/rtl/rsa_lp_gcd.sv
module rsa_lp_gcd
   import rsa_lp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  gcd_req_type gcd_req,
   output gcd_rsp_type gcd_rsp
);

   logic [EXP_W-1:0] a_ff, a_in;
   logic [MOD_W-1:0] b_ff, b_in;
   logic             even_ff, even_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             cop_ff, cop_in;

   // binary gcd, one halving or one subtraction per cycle
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      even_in = even_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cop_in = cop_ff;
      if (gcd_req.start) begin
         a_in = gcd_req.a;
         b_in = gcd_req.b;
         even_in = !gcd_req.a[0] && !gcd_req.b[0];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == '0) begin
            cop_in = (b_ff == MOD_W'(1)) && !even_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (b_ff == '0) begin
            cop_in = (a_ff == EXP_W'(1)) && !even_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0]) begin
            a_in = {1'b0, a_ff[EXP_W-1:1]};
         end else if (!b_ff[0]) begin
            b_in = {1'b0, b_ff[MOD_W-1:1]};
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cop_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cop_ff <= cop_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      even_ff <= even_in;
   end

   assign gcd_rsp.done = done_ff;
   assign gcd_rsp.coprime = cop_ff;

endmodule

>>> hw/rtl/rsa_textbook_letter_pair_encrypt.sv
// Letter pair RSA encryptor.
// Characters arrive on the req_ stream (tdata = character byte, tlast = end
// of message); one transaction is taken whenever the block is idle.
// Letters A..Z are paired into first*100+second (a lone final letter stands
// alone) and each block is raised to the public exponent mod p*q.
// Results leave on the rsp_ stream: tdata = ciphertext, tuser = status
// (0 ok, 1 invalid character, 2 key rejected), tlast = last result of message.
// The first character of a message runs a key check (binary gcd of e and
// (p-1)(q-1)), one halving or subtraction per cycle. Every modular multiply
// is bit-serial, with a handoff to and from the sequencer. A block takes one
// reduction multiply, one square per exponent bit below the top one and one
// multiply per set bit. A character that only opens a pair passes through
// setup and decode and returns to idle; one dropped after an error is
// discarded while idle. The result register frees the input side: the next
// character is taken while a result waits; a stalled receiver blocks the
// block only when a second result is ready. Reset restores p = 61, q = 53,
// e = 17 and clears the message tracking, held letter and pending result.
module rsa_textbook_letter_pair_encrypt
   import rsa_lp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // req_tdata: char_code[7:0]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CHAR_W-1:0]   req_tdata,
   input  logic                req_tlast,
   // rsp_tdata: cipher_value[31:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [MOD_W-1:0]    rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [EXP_W-1:0]    csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SETUP   = 7'b0000010,
      ST_GCD     = 7'b0000100,
      ST_CHAR    = 7'b0001000,
      ST_MM_WAIT = 7'b0010000,
      ST_POW     = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE = 2'd0,
      OP_MUL    = 2'd1,
      OP_SQR    = 2'd2
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [PRIME_W-1:0]  p_ff, q_ff;
   logic [EXP_W-1:0]    e_cfg_ff;
   logic [MOD_W-1:0]    n_ff, phi_ff;

   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                first_ff, first_in;
   logic                mid_ff, mid_in;
   logic                drop_ff, drop_in;
   logic                half_ff, half_in;
   logic [LETTER_W-1:0] held_ff, held_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [MOD_W-1:0]    res_ff, res_in;
   logic [MOD_W-1:0]    base_ff, base_in;
   logic                mdone_ff, mdone_in;
   logic [MOD_W-1:0]    out_val_ff, out_val_in;
   logic [1:0]          out_stat_ff, out_stat_in;
   logic                out_done_ff, out_done_in;
   logic [MOD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CHAR_W-1:0]   letter_full;
   logic [LETTER_W-1:0] letter;
   logic                is_letter;
   logic [BLOCK_W-1:0]  block;
   logic                key_bad;

   mm_req_type  mm_req;
   mm_rsp_type  mm_rsp;
   gcd_req_type gcd_req;
   gcd_rsp_type gcd_rsp;

   rsa_lp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   rsa_lp_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .gcd_req (gcd_req),
      .gcd_rsp (gcd_rsp)
   );

   // configuration registers and derived key values
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= PRIME_W'(61);
         q_ff <= PRIME_W'(53);
         e_cfg_ff <= EXP_W'(17);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PRIME_P:  p_ff <= csr_wdata[PRIME_W-1:0];
            CSR_PRIME_Q:  q_ff <= csr_wdata[PRIME_W-1:0];
            CSR_EXPONENT: e_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
      n_ff <= MOD_W'(p_ff * q_ff);
      phi_ff <= MOD_W'((p_ff - 1'b1) * (q_ff - 1'b1));
   end

   // letter decode and pair block
   assign letter_full = char_ff - LETTER_FIRST;
   assign letter = letter_full[LETTER_W-1:0];
   assign is_letter = (char_ff >= LETTER_FIRST) && (char_ff <= LETTER_LAST);
   assign block = half_ff ? BLOCK_W'(held_ff * PAIR_BASE) + BLOCK_W'(letter)
                          : BLOCK_W'(letter);
   assign key_bad = (p_ff < PRIME_W'(2)) || (q_ff < PRIME_W'(2)) || (n_ff < MOD_W'(2));

   // control sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      char_in = char_ff;
      last_in = last_ff;
      first_in = first_ff;
      mid_in = mid_ff;
      drop_in = drop_ff;
      half_in = half_ff;
      held_in = held_ff;
      exp_in = exp_ff;
      res_in = res_ff;
      base_in = base_ff;
      mdone_in = mdone_ff;
      out_val_in = out_val_ff;
      out_stat_in = out_stat_ff;
      out_done_in = out_done_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mm_req.start = 1'b0;
      mm_req.a = res_ff;
      mm_req.b = base_ff;
      mm_req.n = n_ff;
      gcd_req.start = 1'b0;
      gcd_req.a = e_cfg_ff;
      gcd_req.b = phi_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               char_in = req_tdata;
               last_in = req_tlast;
               first_in = !mid_ff;
               mid_in = !req_tlast;
               if (mid_ff && drop_ff) begin
                  drop_in = !req_tlast;
               end else begin
                  drop_in = 1'b0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (!first_ff) begin
               state_in = ST_CHAR;
            end else if (key_bad) begin
               half_in = 1'b0;
               held_in = '0;
               drop_in = !last_ff;
               out_val_in = '0;
               out_stat_in = STATUS_KEY_REJECT;
               out_done_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               gcd_req.start = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_rsp.done) begin
               if (gcd_rsp.coprime) begin
                  state_in = ST_CHAR;
               end else begin
                  half_in = 1'b0;
                  held_in = '0;
                  drop_in = !last_ff;
                  out_val_in = '0;
                  out_stat_in = STATUS_KEY_REJECT;
                  out_done_in = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_CHAR: begin
            if (!is_letter) begin
               half_in = 1'b0;
               held_in = '0;
               drop_in = !last_ff;
               out_val_in = '0;
               out_stat_in = STATUS_BAD_CHAR;
               out_done_in = 1'b1;
               state_in = ST_OUT;
            end else if (!half_ff && !last_ff) begin
               half_in = 1'b1;
               held_in = letter;
               state_in = ST_IDLE;
            end else begin
               half_in = 1'b0;
               held_in = '0;
               if (n_ff < MOD_W'(2)) begin
                  drop_in = !last_ff;
                  out_val_in = '0;
                  out_stat_in = STATUS_KEY_REJECT;
                  out_done_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  // block mod n as a multiply by one
                  mm_req.start = 1'b1;
                  mm_req.a = MOD_W'(1);
                  mm_req.b = MOD_W'(block);
                  op_in = OP_REDUCE;
                  state_in = ST_MM_WAIT;
               end
            end
         end
         ST_MM_WAIT: begin
            if (mm_rsp.done) begin
               state_in = ST_POW;
               case (op_ff)
                  OP_REDUCE: begin
                     base_in = mm_rsp.value;
                     res_in = MOD_W'(1);
                     mdone_in = 1'b0;
                     exp_in = e_cfg_ff;
                  end
                  OP_MUL: begin
                     res_in = mm_rsp.value;
                     mdone_in = 1'b1;
                  end
                  OP_SQR: begin
                     base_in = mm_rsp.value;
                     exp_in = {1'b0, exp_ff[EXP_W-1:1]};
                     mdone_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_POW: begin
            // square-and-multiply, exponent bits from the bottom
            if (exp_ff == '0) begin
               out_val_in = res_ff;
               out_stat_in = STATUS_OK;
               out_done_in = last_ff;
               state_in = ST_OUT;
            end else if (exp_ff[0] && !mdone_ff) begin
               mm_req.start = 1'b1;
               mm_req.a = res_ff;
               mm_req.b = base_ff;
               op_in = OP_MUL;
               state_in = ST_MM_WAIT;
            end else if (exp_ff[EXP_W-1:1] == '0) begin
               exp_in = '0;
               mdone_in = 1'b0;
            end else begin
               mm_req.start = 1'b1;
               mm_req.a = base_ff;
               mm_req.b = base_ff;
               op_in = OP_SQR;
               state_in = ST_MM_WAIT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = out_val_ff;
               rsp_user_in = out_stat_ff;
               rsp_last_in = out_done_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_REDUCE;
         mid_ff <= 1'b0;
         drop_ff <= 1'b0;
         half_ff <= 1'b0;
         held_ff <= '0;
         mdone_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         mid_ff <= mid_in;
         drop_ff <= drop_in;
         half_ff <= half_in;
         held_ff <= held_in;
         mdone_ff <= mdone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      first_ff <= first_in;
      exp_ff <= exp_in;
      res_ff <= res_in;
      base_ff <= base_in;
      out_val_ff <= out_val_in;
      out_stat_ff <= out_stat_in;
      out_done_ff <= out_done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

   // multiplier is never running while a new character can enter
   a_idle_mm: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mm_rsp.busy)
      else $error("multiplier busy while idle");

   // an error result carries zero data and closes the message
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> ((rsp_tdata == '0) && rsp_tlast))
      else $error("error result with data or without last");

   // multiplier completions only arrive while waiting for them
   a_mm_done: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == ST_MM_WAIT))
      else $error("unexpected multiplier completion");

   // the running result stays below the modulus throughout the exponent loop
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW) |-> (res_ff < n_ff))
      else $error("partial result not reduced");

endmodule
